### hw/rtl/rigid_body_angular_velocity_update_defines.svh
// Assertion macros shared by the angular velocity update RTL.
// No dependencies; each user module must have clk and rst_n in scope.
`ifndef RIGID_BODY_ANGULAR_VELOCITY_UPDATE_DEFINES_SVH
`define RIGID_BODY_ANGULAR_VELOCITY_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RBAV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RBAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rbav_pkg.sv
// Package for the angular velocity update: item types, register codes,
// latencies and saturating arithmetic helpers. No dependencies.
package rbav_pkg;

    localparam int FIX_W  = 32;
    localparam int WORD_W = 64;

    localparam logic signed [63:0] W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] W_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SPAN = 2'd1;

    localparam int ITERATIONS_DEF = 1;

    // Latencies in cycles
    localparam int MUL_LAT  = 4;
    localparam int DIV_LAT  = 83;
    localparam int PRE_LAT  = 11;
    localparam int ITER_LAT = 24 + DIV_LAT;

    typedef struct packed {
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic signed [31:0] omega_x;
        logic signed [31:0] omega_y;
        logic signed [31:0] omega_z;
        logic signed [31:0] inertia_xx;
        logic signed [31:0] inertia_yy;
        logic signed [31:0] inertia_zz;
        logic signed [31:0] inertia_xy;
        logic signed [31:0] inertia_xz;
        logic signed [31:0] inertia_yz;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_omega_x;
        logic signed [31:0] new_omega_y;
        logic signed [31:0] new_omega_z;
        logic               singular;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec32_t;

    // Per-item values carried alongside every iteration
    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic signed [63:0] dzy;
        logic signed [63:0] dxz;
        logic signed [63:0] dyx;
        logic signed [63:0] a00;
        logic signed [63:0] a01;
        logic signed [63:0] a02;
        logic signed [63:0] a11;
        logic signed [63:0] a12;
        logic signed [63:0] a22;
        logic signed [63:0] det;
        logic signed [63:0] m_x;
        logic signed [63:0] m_y;
        logic signed [63:0] m_z;
        vec32_t             w0;
    } ctx_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(W_MAX)) return W_MAX;
        if (s < 65'(W_MIN)) return W_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return sat_add(a, -b);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [64:0] s);
        if (s > 65'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -65'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

endpackage

### hw/rtl/rbav_delay.sv
// Enabled delay line of fixed depth for aligning operands in the pipeline.
// No dependencies.
module rbav_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] stage_reg [DEPTH];

    // Shift along the line while the pipeline advances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule

### hw/rtl/rbav_mul.sv
// Four-stage Q16.16 multiplier: 64x64 magnitudes from four 32x32 partial
// products, shift by 16 or 17, round half away from zero, saturate. Uses rbav_pkg.
module rbav_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic               half,
    output logic signed [63:0] p
);
    import rbav_pkg::*;

    logic        neg1_reg, half1_reg;
    logic [63:0] ua_reg, ub_reg;
    logic        neg2_reg, half2_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        neg3_reg, half3_reg;
    logic [127:0] sum_reg;
    logic signed [63:0] p_reg;
    logic [127:0] rnd;
    logic [63:0]  r;
    logic         ovf;

    // Stage one: sign and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= a[63] ^ b[63];
            half1_reg <= half;
            ua_reg    <= a[63] ? 64'(-a) : 64'(a);
            ub_reg    <= b[63] ? 64'(-b) : 64'(b);
        end
    end

    // Stage two: partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg  <= neg1_reg;
            half2_reg <= half1_reg;
            p00_reg   <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg   <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg   <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg   <= ua_reg[63:32] * ub_reg[63:32];
        end
    end

    // Stage three: full product plus rounding bit
    assign rnd = {111'b0, half2_reg, ~half2_reg, 15'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg  <= neg2_reg;
            half3_reg <= half2_reg;
            sum_reg   <= {64'b0, p00_reg} + {32'b0, p01_reg, 32'b0}
                       + {32'b0, p10_reg, 32'b0} + {p11_reg, 64'b0} + rnd;
        end
    end

    // Stage four: shift, saturate and restore the sign
    assign r   = half3_reg ? sum_reg[80:17] : sum_reg[79:16];
    assign ovf = half3_reg ? (|sum_reg[127:80]) : (|sum_reg[127:79]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf)
            begin
                p_reg <= neg3_reg ? W_MIN : W_MAX;
            end
            else
            begin
                p_reg <= neg3_reg ? -$signed(r) : $signed(r);
            end
        end
    end

    assign p = p_reg;

endmodule

### hw/rtl/rbav_div.sv
// Pipelined restoring divider: num*2^16/den, one quotient bit per stage over
// 80 stages, rounded half away from zero and saturated. Uses rbav_pkg.
module rbav_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] q
);
    import rbav_pkg::*;

    localparam int STEPS = 80;

    logic [63:0] un_reg   [STEPS];
    logic [63:0] ud_reg   [STEPS];
    logic [63:0] r_reg    [STEPS];
    logic [63:0] q_reg    [STEPS+1];
    logic        over_reg [STEPS+1];
    logic        neg_reg  [STEPS+1];
    logic [63:0] qr_reg;
    logic        sat_reg;
    logic        negf_reg;
    logic signed [63:0] q_out_reg;

    // Entry stage: magnitudes, clear remainder and quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg[0]   <= num[63] ? 64'(-num) : 64'(num);
            ud_reg[0]   <= den[63] ? 64'(-den) : 64'(den);
            r_reg[0]    <= '0;
            q_reg[0]    <= '0;
            over_reg[0] <= 1'b0;
            neg_reg[0]  <= num[63] ^ den[63];
        end
    end

    // One compare and subtract per stage
    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        localparam int I = STEPS - k;
        logic        bitv;
        logic [64:0] r_sh;
        logic        ge;
        logic [64:0] r_new;

        if (I >= 17)
        begin : g_num_bit
            assign bitv = un_reg[k-1][I-17];
        end
        else
        begin : g_zero_bit
            assign bitv = 1'b0;
        end

        assign r_sh  = {r_reg[k-1], bitv};
        assign ge    = r_sh >= {1'b0, ud_reg[k-1]};
        assign r_new = ge ? (r_sh - {1'b0, ud_reg[k-1]}) : r_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]    <= {q_reg[k-1][62:0], ge};
                over_reg[k] <= over_reg[k-1] | q_reg[k-1][63];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end

        if (k < STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    un_reg[k] <= un_reg[k-1];
                    ud_reg[k] <= ud_reg[k-1];
                    r_reg[k]  <= r_new[63:0];
                end
            end
        end
    end

    // Round the extra quotient bit away
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qr_reg   <= {1'b0, q_reg[STEPS][63:1]} + {63'b0, q_reg[STEPS][0]};
            sat_reg  <= over_reg[STEPS];
            negf_reg <= neg_reg[STEPS];
        end
    end

    // Saturate and restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sat_reg || qr_reg[63])
            begin
                q_out_reg <= negf_reg ? W_MIN : W_MAX;
            end
            else
            begin
                q_out_reg <= negf_reg ? -$signed(qr_reg) : $signed(qr_reg);
            end
        end
    end

    assign q = q_out_reg;

endmodule

### hw/rtl/rbav_iter.sv
// One update iteration: gyroscopic term, moment difference, adjugate product,
// division by the determinant and the half-step update. Uses rbav_pkg,
// rbav_mul, rbav_div and rbav_delay.
module rbav_iter (
    input  logic                 clk,
    input  logic                 en,
    input  logic [30:0]          step_span,
    input  rbav_pkg::ctx_t       ctx_in,
    input  rbav_pkg::vec32_t     wn_in,
    output rbav_pkg::ctx_t       ctx_out,
    output rbav_pkg::vec32_t     wn_out
);
    import rbav_pkg::*;

    ctx_t c4, c12, c13, c19, c23;

    logic signed [63:0] wx, wy, wz;
    logic signed [63:0] sq_a [6];
    logic signed [63:0] sq_b [6];
    logic signed [63:0] sq_p [6];
    logic signed [63:0] pyz, pzx, pxy, sxx, syy, szz;
    logic signed [63:0] t_a [15];
    logic signed [63:0] t_b [15];
    logic signed [63:0] t_p [15];
    logic signed [63:0] g_m [3];
    logic signed [63:0] dd_reg [3];
    logic signed [63:0] v_a [9];
    logic signed [63:0] v_b [9];
    logic signed [63:0] v_p [9];
    logic signed [63:0] vs_reg [3];
    logic signed [63:0] vt_reg [3];
    logic signed [63:0] v_reg [3];
    logic signed [63:0] acc [3];
    logic signed [63:0] dv [3];
    logic signed [31:0] w0k [3];
    logic signed [31:0] wn_reg [3];

    // Carry the item context alongside the arithmetic
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(4)) u_dly4
        (.clk, .en, .d(ctx_in), .q(c4));
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(8)) u_dly12
        (.clk, .en, .d(c4), .q(c12));
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(1)) u_dly13
        (.clk, .en, .d(c12), .q(c13));
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(6)) u_dly19
        (.clk, .en, .d(c13), .q(c19));
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(DIV_LAT + 4)) u_dly23
        (.clk, .en, .d(c19), .q(c23));
    rbav_delay #(.W($bits(ctx_t)), .DEPTH(1)) u_dly_out
        (.clk, .en, .d(c23), .q(ctx_out));

    // Squares and cross products of the current iterate
    assign wx = 64'(wn_in.x);
    assign wy = 64'(wn_in.y);
    assign wz = 64'(wn_in.z);

    assign sq_a[0] = wy;  assign sq_b[0] = wz;
    assign sq_a[1] = wz;  assign sq_b[1] = wx;
    assign sq_a[2] = wx;  assign sq_b[2] = wy;
    assign sq_a[3] = wx;  assign sq_b[3] = wx;
    assign sq_a[4] = wy;  assign sq_b[4] = wy;
    assign sq_a[5] = wz;  assign sq_b[5] = wz;

    for (genvar j = 0; j < 6; j++)
    begin : g_sq_mul
        rbav_mul u_mul (.clk, .en, .a(sq_a[j]), .b(sq_b[j]), .half(1'b0), .p(sq_p[j]));
    end

    assign pyz = sq_p[0];
    assign pzx = sq_p[1];
    assign pxy = sq_p[2];
    assign sxx = sq_p[3];
    assign syy = sq_p[4];
    assign szz = sq_p[5];

    // Gyroscopic terms, five per axis
    assign t_a[0]  = pyz;  assign t_b[0]  = c4.dzy;
    assign t_a[1]  = szz;  assign t_b[1]  = 64'(c4.yz);
    assign t_a[2]  = syy;  assign t_b[2]  = 64'(c4.yz);
    assign t_a[3]  = pxy;  assign t_b[3]  = 64'(c4.xz);
    assign t_a[4]  = pzx;  assign t_b[4]  = 64'(c4.xy);
    assign t_a[5]  = pzx;  assign t_b[5]  = c4.dxz;
    assign t_a[6]  = sxx;  assign t_b[6]  = 64'(c4.xz);
    assign t_a[7]  = szz;  assign t_b[7]  = 64'(c4.xz);
    assign t_a[8]  = pyz;  assign t_b[8]  = 64'(c4.xy);
    assign t_a[9]  = pxy;  assign t_b[9]  = 64'(c4.yz);
    assign t_a[10] = pxy;  assign t_b[10] = c4.dyx;
    assign t_a[11] = syy;  assign t_b[11] = 64'(c4.xy);
    assign t_a[12] = sxx;  assign t_b[12] = 64'(c4.xy);
    assign t_a[13] = pzx;  assign t_b[13] = 64'(c4.yz);
    assign t_a[14] = pyz;  assign t_b[14] = 64'(c4.xz);

    for (genvar j = 0; j < 15; j++)
    begin : g_term_mul
        rbav_mul u_mul (.clk, .en, .a(t_a[j]), .b(t_b[j]), .half(1'b0), .p(t_p[j]));
    end

    assign g_m[0] = c12.m_x;
    assign g_m[1] = c12.m_y;
    assign g_m[2] = c12.m_z;

    // Accumulate each axis in order, then subtract from the moment
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        localparam int B = 5 * g;
        logic signed [63:0] g1_reg, g2_reg, g3_reg, g4_reg;
        logic signed [63:0] t3a_reg, t4a_reg, t4b_reg, t5a_reg, t5b_reg, t5c_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                g1_reg  <= sat_sub(t_p[B], t_p[B+1]);
                t3a_reg <= t_p[B+2];
                t4a_reg <= t_p[B+3];
                t5a_reg <= t_p[B+4];
                g2_reg  <= sat_add(g1_reg, t3a_reg);
                t4b_reg <= t4a_reg;
                t5b_reg <= t5a_reg;
                g3_reg  <= sat_add(g2_reg, t4b_reg);
                t5c_reg <= t5b_reg;
                g4_reg  <= sat_sub(g3_reg, t5c_reg);
                dd_reg[g] <= sat_sub(g_m[g], g4_reg);
            end
        end
    end

    // Adjugate times moment difference
    assign v_a[0] = c13.a00;  assign v_b[0] = dd_reg[0];
    assign v_a[1] = c13.a01;  assign v_b[1] = dd_reg[1];
    assign v_a[2] = c13.a02;  assign v_b[2] = dd_reg[2];
    assign v_a[3] = c13.a01;  assign v_b[3] = dd_reg[0];
    assign v_a[4] = c13.a11;  assign v_b[4] = dd_reg[1];
    assign v_a[5] = c13.a12;  assign v_b[5] = dd_reg[2];
    assign v_a[6] = c13.a02;  assign v_b[6] = dd_reg[0];
    assign v_a[7] = c13.a12;  assign v_b[7] = dd_reg[1];
    assign v_a[8] = c13.a22;  assign v_b[8] = dd_reg[2];

    for (genvar j = 0; j < 9; j++)
    begin : g_adj_mul
        rbav_mul u_mul (.clk, .en, .a(v_a[j]), .b(v_b[j]), .half(1'b0), .p(v_p[j]));
    end

    assign w0k[0] = c23.w0.x;
    assign w0k[1] = c23.w0.y;
    assign w0k[2] = c23.w0.z;

    for (genvar k = 0; k < 3; k++)
    begin : g_out
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vs_reg[k] <= sat_add(v_p[3*k], v_p[3*k+1]);
                vt_reg[k] <= v_p[3*k+2];
                v_reg[k]  <= sat_add(vs_reg[k], vt_reg[k]);
            end
        end

        // Divide by the determinant, scale by half the step, add to start value
        rbav_div u_div (.clk, .en, .num(v_reg[k]), .den(c19.det), .q(acc[k]));

        rbav_mul u_step (.clk, .en, .a($signed({33'b0, step_span})), .b(acc[k]),
                         .half(1'b1), .p(dv[k]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                wn_reg[k] <= clamp32(65'(w0k[k]) + 65'(dv[k]));
            end
        end
    end

    assign wn_out.x = wn_reg[0];
    assign wn_out.y = wn_reg[1];
    assign wn_out.z = wn_reg[2];

endmodule

### hw/rtl/rigid_body_angular_velocity_update.sv
// Rigid-body angular velocity half step in Q16.16. One item enters per cycle
// unless a finished result is held back by out_stall. Each item passes
// through the input register, the preamble (adjugate, determinant, damped
// moment), the iteration pipeline, whose 80-stage one-bit-per-stage divider
// is the longest part, and the output register. A stalled output freezes the
// whole pipeline; nothing is dropped. A zero determinant returns the input
// omega with singular set. Registers damping and step_span are written through
// the cfg port; the user must do so only while the block is idle, which the
// block itself leaves unenforced. There is no initialisation sequence after
// reset.
module rigid_body_angular_velocity_update #(
    parameter int ITERATIONS = rbav_pkg::ITERATIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rbav_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rbav_pkg::out_item_t               out_item,
    input  logic                              cfg_wr_en,
    input  logic [rbav_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbav_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import rbav_pkg::*;

`include "rigid_body_angular_velocity_update_defines.svh"

    localparam int LAT = PRE_LAT + ITERATIONS * ITER_LAT + 2;

    logic [CFG_DATA_W-1:0] damping_reg, step_span_reg;
    logic [LAT-1:0]        vld_reg, vld_next;
    logic                  en;
    in_item_t              in_reg, in_d5, in_d11;
    out_item_t             out_reg;

    logic signed [63:0] adj_a [12];
    logic signed [63:0] adj_b [12];
    logic signed [63:0] adj_p [12];
    logic signed [63:0] adj_reg [6];
    logic signed [63:0] dmp_a [3];
    logic signed [63:0] dmp_p [3];
    logic signed [63:0] tq_d [3];
    logic [95:0]        tq_d4;
    logic signed [63:0] m_reg [3];
    logic signed [63:0] det_a [3];
    logic signed [63:0] det_p [3];
    logic signed [63:0] ds_reg, dt_reg, det_reg;
    logic signed [63:0] diff_reg [3];
    logic [575:0]       adjm_d;
    logic [191:0]       diff_d;
    ctx_t               ctx_s [ITERATIONS+1];
    vec32_t             wn_s  [ITERATIONS+1];
    logic               sing;

    // Advance everything unless a finished result is held back
    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];
    assign out_item  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg   <= '0;
            step_span_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DAMPING:   damping_reg   <= cfg_wr_data;
                CFG_STEP_SPAN: step_span_reg <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    // Valid bits travel with the items
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= in_item;
        end
    end

    // Adjugate products
    assign adj_a[0]  = 64'(in_reg.inertia_yy);  assign adj_b[0]  = 64'(in_reg.inertia_zz);
    assign adj_a[1]  = 64'(in_reg.inertia_yz);  assign adj_b[1]  = 64'(in_reg.inertia_yz);
    assign adj_a[2]  = 64'(in_reg.inertia_xz);  assign adj_b[2]  = 64'(in_reg.inertia_yz);
    assign adj_a[3]  = 64'(in_reg.inertia_xy);  assign adj_b[3]  = 64'(in_reg.inertia_zz);
    assign adj_a[4]  = 64'(in_reg.inertia_xy);  assign adj_b[4]  = 64'(in_reg.inertia_yz);
    assign adj_a[5]  = 64'(in_reg.inertia_xz);  assign adj_b[5]  = 64'(in_reg.inertia_yy);
    assign adj_a[6]  = 64'(in_reg.inertia_xx);  assign adj_b[6]  = 64'(in_reg.inertia_zz);
    assign adj_a[7]  = 64'(in_reg.inertia_xz);  assign adj_b[7]  = 64'(in_reg.inertia_xz);
    assign adj_a[8]  = 64'(in_reg.inertia_xy);  assign adj_b[8]  = 64'(in_reg.inertia_xz);
    assign adj_a[9]  = 64'(in_reg.inertia_xx);  assign adj_b[9]  = 64'(in_reg.inertia_yz);
    assign adj_a[10] = 64'(in_reg.inertia_xx);  assign adj_b[10] = 64'(in_reg.inertia_yy);
    assign adj_a[11] = 64'(in_reg.inertia_xy);  assign adj_b[11] = 64'(in_reg.inertia_xy);

    for (genvar j = 0; j < 12; j++)
    begin : g_adj_mul
        rbav_mul u_mul (.clk, .en, .a(adj_a[j]), .b(adj_b[j]), .half(1'b0), .p(adj_p[j]));
    end

    // Damping products and the delayed torque
    assign dmp_a[0] = 64'(in_reg.omega_x);
    assign dmp_a[1] = 64'(in_reg.omega_y);
    assign dmp_a[2] = 64'(in_reg.omega_z);

    for (genvar j = 0; j < 3; j++)
    begin : g_dmp_mul
        rbav_mul u_mul (.clk, .en, .a($signed({33'b0, damping_reg})), .b(dmp_a[j]),
                        .half(1'b0), .p(dmp_p[j]));
    end

    rbav_delay #(.W(96), .DEPTH(MUL_LAT)) u_tq_dly
        (.clk, .en, .d({in_reg.torque_x, in_reg.torque_y, in_reg.torque_z}), .q(tq_d4));

    assign tq_d[0] = 64'($signed(tq_d4[95:64]));
    assign tq_d[1] = 64'($signed(tq_d4[63:32]));
    assign tq_d[2] = 64'($signed(tq_d4[31:0]));

    // Adjugate entries and damped moment
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 6; j++)
            begin
                adj_reg[j] <= sat_sub(adj_p[2*j], adj_p[2*j+1]);
            end
            for (int j = 0; j < 3; j++)
            begin
                m_reg[j] <= sat_sub(tq_d[j], dmp_p[j]);
            end
        end
    end

    // Determinant along the first row
    rbav_delay #(.W($bits(in_item_t)), .DEPTH(5)) u_in_dly5
        (.clk, .en, .d(in_reg), .q(in_d5));
    rbav_delay #(.W($bits(in_item_t)), .DEPTH(6)) u_in_dly11
        (.clk, .en, .d(in_d5), .q(in_d11));

    assign det_a[0] = 64'(in_d5.inertia_xx);
    assign det_a[1] = 64'(in_d5.inertia_xy);
    assign det_a[2] = 64'(in_d5.inertia_xz);

    for (genvar j = 0; j < 3; j++)
    begin : g_det_mul
        rbav_mul u_mul (.clk, .en, .a(det_a[j]), .b(adj_reg[j]), .half(1'b0), .p(det_p[j]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_reg  <= sat_add(det_p[0], det_p[1]);
            dt_reg  <= det_p[2];
            det_reg <= sat_add(ds_reg, dt_reg);
        end
    end

    // Diagonal differences for the gyroscopic term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg[0] <= sat_sub(64'(in_reg.inertia_zz), 64'(in_reg.inertia_yy));
            diff_reg[1] <= sat_sub(64'(in_reg.inertia_xx), 64'(in_reg.inertia_zz));
            diff_reg[2] <= sat_sub(64'(in_reg.inertia_yy), 64'(in_reg.inertia_xx));
        end
    end

    rbav_delay #(.W(576), .DEPTH(6)) u_adjm_dly
        (.clk, .en,
         .d({adj_reg[0], adj_reg[1], adj_reg[2], adj_reg[3], adj_reg[4], adj_reg[5],
             m_reg[0], m_reg[1], m_reg[2]}),
         .q(adjm_d));
    rbav_delay #(.W(192), .DEPTH(10)) u_diff_dly
        (.clk, .en, .d({diff_reg[0], diff_reg[1], diff_reg[2]}), .q(diff_d));

    // Assemble the context for the first iteration
    assign ctx_s[0].xx   = in_d11.inertia_xx;
    assign ctx_s[0].yy   = in_d11.inertia_yy;
    assign ctx_s[0].zz   = in_d11.inertia_zz;
    assign ctx_s[0].xy   = in_d11.inertia_xy;
    assign ctx_s[0].xz   = in_d11.inertia_xz;
    assign ctx_s[0].yz   = in_d11.inertia_yz;
    assign ctx_s[0].dzy  = diff_d[191:128];
    assign ctx_s[0].dxz  = diff_d[127:64];
    assign ctx_s[0].dyx  = diff_d[63:0];
    assign ctx_s[0].a00  = adjm_d[575:512];
    assign ctx_s[0].a01  = adjm_d[511:448];
    assign ctx_s[0].a02  = adjm_d[447:384];
    assign ctx_s[0].a11  = adjm_d[383:320];
    assign ctx_s[0].a12  = adjm_d[319:256];
    assign ctx_s[0].a22  = adjm_d[255:192];
    assign ctx_s[0].m_x  = adjm_d[191:128];
    assign ctx_s[0].m_y  = adjm_d[127:64];
    assign ctx_s[0].m_z  = adjm_d[63:0];
    assign ctx_s[0].det  = det_reg;
    assign ctx_s[0].w0.x = in_d11.omega_x;
    assign ctx_s[0].w0.y = in_d11.omega_y;
    assign ctx_s[0].w0.z = in_d11.omega_z;
    assign wn_s[0]       = ctx_s[0].w0;

    // Chain of iteration pipelines
    for (genvar n = 0; n < ITERATIONS; n++)
    begin : g_iter
        rbav_iter u_iter (
            .clk,
            .en,
            .step_span (step_span_reg),
            .ctx_in    (ctx_s[n]),
            .wn_in     (wn_s[n]),
            .ctx_out   (ctx_s[n+1]),
            .wn_out    (wn_s[n+1])
        );
    end

    // Output register: pass omega through on a singular tensor
    assign sing = (ctx_s[ITERATIONS].det == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.new_omega_x <= sing ? ctx_s[ITERATIONS].w0.x : wn_s[ITERATIONS].x;
            out_reg.new_omega_y <= sing ? ctx_s[ITERATIONS].w0.y : wn_s[ITERATIONS].y;
            out_reg.new_omega_z <= sing ? ctx_s[ITERATIONS].w0.z : wn_s[ITERATIONS].z;
            out_reg.singular    <= sing;
        end
    end

    // Checks
    `RBAV_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_reg[0], "accepted item not in pipeline")
    `RBAV_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_reg), "pipeline moved while stalled")
    `RBAV_ASSERT_NEXT(a_cfg_damping, cfg_wr_en && cfg_index == CFG_DAMPING, damping_reg == $past(cfg_wr_data), "damping write lost")

endmodule
